### rtl/irfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfe_pkg
// shared widths, register indexes, framing codes and control structs of the
// ir remote frame encoder
// ----------------------------------------------------------------------------
package irfe_pkg;

	localparam int PAYLOAD_W    = 32;
	localparam int DUR_W        = 16;
	localparam int BITCNT_W     = 6;
	localparam int MODE_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int MAX_BITS_DEF = 32;
	// signed alignment offset, also holds a saturated bit count
	localparam int ALIGN_W      = BITCNT_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd6;

	// framing codes
	localparam logic [MODE_W-1:0] MODE_PDIST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PWIDTH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MANCH  = 2'd2;

	// reset values
	localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
	localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4500;
	localparam logic [DUR_W-1:0] RST_ONE_MARK     = 16'd560;
	localparam logic [DUR_W-1:0] RST_ZERO_MARK    = 16'd560;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1690;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;

	typedef struct packed {
		logic [MODE_W-1:0] frame_mode;
		logic [DUR_W-1:0]  header_mark_us;
		logic [DUR_W-1:0]  header_space_us;
		logic [DUR_W-1:0]  one_mark_us;
		logic [DUR_W-1:0]  zero_mark_us;
		logic [DUR_W-1:0]  one_space_us;
		logic [DUR_W-1:0]  zero_space_us;
	} timing_t;

	typedef struct packed {
		logic load;
		logic step;
	} shift_ctrl_t;

	typedef struct packed {
		logic aligned;
		logic bit_val;
	} shift_stat_t;

endpackage

### rtl/irfe_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfe channel interfaces
// frame command, pulse pair and register write channels
// ----------------------------------------------------------------------------
interface irfe_cmd_if import irfe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PAYLOAD_W-1:0] payload;
	logic [BITCNT_W-1:0]  bit_count;

	modport source (output valid, output payload, output bit_count, input ready);
	modport sink   (input valid, input payload, input bit_count, output ready);
endinterface

interface irfe_pair_if import irfe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mark_first;
	logic [DUR_W-1:0] first_duration_us;
	logic [DUR_W-1:0] second_duration_us;
	logic             last_pair;

	modport source (output valid, output mark_first, output first_duration_us,
		output second_duration_us, output last_pair, input ready);
	modport sink   (input valid, input mark_first, input first_duration_us,
		input second_duration_us, input last_pair, output ready);
endinterface

interface irfe_cfg_if import irfe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/irfe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfe_cfg_regs
// framing mode and timing registers behind the write channel
// ----------------------------------------------------------------------------
module irfe_cfg_regs import irfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	irfe_cfg_if.sink   cfg,
	output timing_t    tm
);

	timing_t tm_q;

	assign cfg.ready = 1'b1;
	assign tm        = tm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tm_q.frame_mode      <= MODE_PDIST;
			tm_q.header_mark_us  <= RST_HEADER_MARK;
			tm_q.header_space_us <= RST_HEADER_SPACE;
			tm_q.one_mark_us     <= RST_ONE_MARK;
			tm_q.zero_mark_us    <= RST_ZERO_MARK;
			tm_q.one_space_us    <= RST_ONE_SPACE;
			tm_q.zero_space_us   <= RST_ZERO_SPACE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_MODE:   tm_q.frame_mode      <= cfg.data[MODE_W-1:0];
				REG_HEADER_MARK:  tm_q.header_mark_us  <= cfg.data;
				REG_HEADER_SPACE: tm_q.header_space_us <= cfg.data;
				REG_ONE_MARK:     tm_q.one_mark_us     <= cfg.data;
				REG_ZERO_MARK:    tm_q.zero_mark_us    <= cfg.data;
				REG_ONE_SPACE:    tm_q.one_space_us    <= cfg.data;
				REG_ZERO_SPACE:   tm_q.zero_space_us   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/irfe_bit_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfe_bit_shifter
// payload shift register with a signed alignment counter; bits leave msb first
// ----------------------------------------------------------------------------
module irfe_bit_shifter import irfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shift_ctrl_t          ctrl,
	input  logic [PAYLOAD_W-1:0] payload,
	input  logic [ALIGN_W-1:0]   align_init,
	output shift_stat_t          stat
);

	logic [PAYLOAD_W-1:0] sreg_q;
	logic [ALIGN_W-1:0]   align_q;
	logic                 align_neg;
	logic                 align_pos;

	// positive: bits still to drop, negative: leading zeros still to send
	assign align_neg = align_q[ALIGN_W-1];
	assign align_pos = !align_neg && (align_q != '0);

	assign stat.aligned = !align_pos;
	assign stat.bit_val = align_neg ? 1'b0 : sreg_q[PAYLOAD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= '0;
		end else if (ctrl.load) begin
			align_q <= align_init;
		end else if (ctrl.step) begin
			if (align_pos) begin
				align_q <= align_q - ALIGN_W'(1);
			end else if (align_neg) begin
				align_q <= align_q + ALIGN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sreg_q <= payload;
		end else if (ctrl.step && !align_neg) begin
			sreg_q <= {sreg_q[PAYLOAD_W-2:0], 1'b0};
		end
	end

endmodule

### rtl/irfe_frame_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfe_frame_seq
// frame sequencer: walks header, bit and closing pairs and holds the output
// register of the pair channel
// ----------------------------------------------------------------------------
module irfe_frame_seq import irfe_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  timing_t             tm,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic [BITCNT_W-1:0] bit_count,
	output shift_ctrl_t         sh_ctrl,
	output logic [ALIGN_W-1:0]  align_init,
	input  shift_stat_t         sh_stat,
	irfe_pair_if.source         pair
);

	localparam int CNT_W = $clog2(MAX_BITS + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ALIGN  = 6'b000010,
		ST_HEAD   = 6'b000100,
		ST_START2 = 6'b001000,
		ST_BITS   = 6'b010000,
		ST_TRAIL  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   rem_q, rem_d;
	logic [ALIGN_W-1:0] bc_ext;
	logic [ALIGN_W-1:0] n_sat;
	logic               acc;
	logic               mode_ok;
	logic               align_pos;
	logic               emit_ok;
	logic               gen;
	logic               mf_d;
	logic [DUR_W-1:0]   d1_d, d2_d;
	logic               last_d;
	logic               step;

	logic               out_valid_q;
	logic               mf_q;
	logic [DUR_W-1:0]   d1_q, d2_q;
	logic               last_q;

	assign cmd_ready = (state_q == ST_IDLE);
	assign acc       = cmd_valid && cmd_ready;

	assign bc_ext = ALIGN_W'(bit_count);
	assign n_sat  = (bc_ext > ALIGN_W'(MAX_BITS)) ? ALIGN_W'(MAX_BITS) : bc_ext;

	assign mode_ok = (tm.frame_mode == MODE_PDIST) || (tm.frame_mode == MODE_PWIDTH)
		|| (tm.frame_mode == MODE_MANCH);

	// msb-first framing needs no alignment, lsb-anchored framing drops 32-n bits
	assign align_init = (tm.frame_mode == MODE_PDIST) ? '0
		: ALIGN_W'(ALIGN_W'(PAYLOAD_W) - n_sat);
	assign align_pos  = !align_init[ALIGN_W-1] && (align_init != '0);

	assign emit_ok = !out_valid_q || pair.ready;

	assign sh_ctrl.load = acc;
	assign sh_ctrl.step = step;

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		gen     = 1'b0;
		mf_d    = 1'b1;
		d1_d    = '0;
		d2_d    = '0;
		last_d  = 1'b0;
		step    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc && mode_ok) begin
					rem_d   = CNT_W'(n_sat);
					state_d = align_pos ? ST_ALIGN : ST_HEAD;
				end
			end
			ST_ALIGN: begin
				if (sh_stat.aligned) begin
					state_d = ST_HEAD;
				end else begin
					step = 1'b1;
				end
			end
			ST_HEAD: begin
				if (emit_ok) begin
					gen = 1'b1;
					if (tm.frame_mode == MODE_MANCH) begin
						d1_d    = tm.one_mark_us;
						d2_d    = tm.one_mark_us;
						state_d = ST_START2;
					end else begin
						d1_d = tm.header_mark_us;
						d2_d = tm.header_space_us;
						if (rem_q != '0) begin
							state_d = ST_BITS;
						end else if (tm.frame_mode == MODE_PDIST) begin
							state_d = ST_TRAIL;
						end else begin
							last_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_START2: begin
				if (emit_ok) begin
					gen     = 1'b1;
					d1_d    = tm.one_mark_us;
					last_d  = (rem_q == '0);
					state_d = (rem_q == '0) ? ST_IDLE : ST_BITS;
				end
			end
			ST_BITS: begin
				if (emit_ok) begin
					gen   = 1'b1;
					step  = 1'b1;
					rem_d = rem_q - CNT_W'(1);
					case (tm.frame_mode)
						MODE_MANCH: begin
							mf_d = !sh_stat.bit_val;
							d1_d = tm.one_mark_us;
							d2_d = tm.one_mark_us;
						end
						MODE_PWIDTH: begin
							d1_d = sh_stat.bit_val ? tm.one_mark_us : tm.zero_mark_us;
							d2_d = tm.header_space_us;
						end
						default: begin
							d1_d = tm.one_mark_us;
							d2_d = sh_stat.bit_val ? tm.one_space_us : tm.zero_space_us;
						end
					endcase
					if (rem_q == CNT_W'(1)) begin
						if (tm.frame_mode == MODE_PDIST) begin
							state_d = ST_TRAIL;
						end else begin
							last_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_TRAIL: begin
				if (emit_ok) begin
					gen     = 1'b1;
					d1_d    = tm.one_mark_us;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (pair.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			mf_q   <= mf_d;
			d1_q   <= d1_d;
			d2_q   <= d2_d;
			last_q <= last_d;
		end
	end

	assign pair.valid              = out_valid_q;
	assign pair.mark_first         = mf_q;
	assign pair.first_duration_us  = d1_q;
	assign pair.second_duration_us = d2_q;
	assign pair.last_pair          = last_q;

endmodule

### rtl/ir_remote_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit
// turns a frame command into a run of ir pulse pairs (nec, sony or rc5 style)
// ----------------------------------------------------------------------------
// Each command (payload, bit_count) becomes a frame of pulse pairs, each
// giving which level comes first and two segment durations in microseconds.
// frame_mode selects pulse distance with trailer (header, n bits taken from
// payload bit 31 downward, trailer mark: n+2 pairs), pulse width (header, n
// bits from bit n-1 downward: n+1 pairs) or manchester (two start pairs, n
// half-bit pairs from bit n-1 downward: n+2 pairs). bit_count saturates at
// MAX_BITS; bit positions outside the 32-bit payload are sent as zero; mode 3
// takes the command and emits nothing. Payload bits leave a shift register
// one per cycle unless the pair channel stalls. Pulse width and manchester
// frames with n below 32 first shift the payload into place, dropping 32-n
// bits, and wait to see it aligned before the header goes out. After that,
// with the consumer always ready, one pair leaves per cycle; stalls on the
// pair channel hold the frame. The next command is taken once the last pair
// of a frame sits in the output register. Timing registers are written over
// the cfg channel, always ready; the user must write them only while no
// frame is in progress, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ir_remote_frame_encoder_unit import irfe_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	irfe_cmd_if.sink    cmd,
	irfe_pair_if.source pair,
	irfe_cfg_if.sink    cfg
);

	timing_t            tm;
	shift_ctrl_t        sh_ctrl;
	shift_stat_t        sh_stat;
	logic [ALIGN_W-1:0] align_init;
	logic               cmd_ready;

	// command transfer handshake lives in the sequencer
	assign cmd.ready = cmd_ready;

	// mode and timing registers
	irfe_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tm     (tm)
	);

	// payload bits, one per step, msb first after alignment
	irfe_bit_shifter u_bit_shifter (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sh_ctrl),
		.payload    (cmd.payload),
		.align_init (align_init),
		.stat       (sh_stat)
	);

	// frame walk and pair output register
	irfe_frame_seq #(
		.MAX_BITS (MAX_BITS)
	) u_frame_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tm         (tm),
		.cmd_valid  (cmd.valid),
		.cmd_ready  (cmd_ready),
		.bit_count  (cmd.bit_count),
		.sh_ctrl    (sh_ctrl),
		.align_init (align_init),
		.sh_stat    (sh_stat),
		.pair       (pair)
	);

endmodule

### tb/ir_remote_frame_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit_test
// self-checking bench for the ir remote frame encoder: frame commands go in
// over the command channel and a local encoder works out the pulse pairs each
// transfer should produce. Every pair that leaves the block is checked field
// by field against the oldest pending one. Phases switch the framing and the
// timing registers, and both channels idle at random.
// ----------------------------------------------------------------------------
module ir_remote_frame_encoder_unit_test;
	import irfe_pkg::*;

	// mode code with no framing behind it, and an index with no register
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

	localparam int CYCLE_LIMIT   = 400_000;
	// cycles left for a frame to finish when no pair signals its end
	localparam int SETTLE_CYCLES = 100;
	localparam int TAIL_CYCLES   = 100;
	localparam int PHASE_COUNT   = 8;
	localparam int RANDOM_CMDS   = 18;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [BITCNT_W-1:0]  bit_count;
	} frame_cmd_t;

	typedef struct packed {
		logic             mark_first;
		logic [DUR_W-1:0] first_us;
		logic [DUR_W-1:0] second_us;
		logic             last_pair;
	} pulse_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	irfe_cmd_if  cmd_ch();
	irfe_pair_if pair_ch();
	irfe_cfg_if  cfg_ch();

	// commands waiting for the driver, pairs waiting for the block
	frame_cmd_t  cmd_backlog[$];
	pulse_pair_t pending_pairs[$];

	// local copy of the timing registers
	timing_t timing_now;

	int cmds_queued = 0;
	int cmds_taken = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	ir_remote_frame_encoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pair   (pair_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// builds the pulse pairs of one frame from the current timing set
	function automatic void encode_frame(input logic [PAYLOAD_W-1:0] bits,
		input logic [BITCNT_W-1:0] count);
		pulse_pair_t frame[$];
		int n;
		logic b;
		// counts above the frame size saturate
		n = (int'(count) > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(count);
		case (timing_now.frame_mode)
		MODE_PDIST: begin
			// header, bits from the top of the payload down, trailer mark
			frame.push_back({1'b1, timing_now.header_mark_us, timing_now.header_space_us, 1'b0});
			for (int i = 0; i < n; i++) begin
				b = bits[31 - i];
				frame.push_back({1'b1, timing_now.one_mark_us,
					b ? timing_now.one_space_us : timing_now.zero_space_us, 1'b0});
			end
			frame.push_back({1'b1, timing_now.one_mark_us, {DUR_W{1'b0}}, 1'b0});
		end
		MODE_PWIDTH: begin
			// right-aligned bits, mark width carries the value
			frame.push_back({1'b1, timing_now.header_mark_us, timing_now.header_space_us, 1'b0});
			for (int i = 0; i < n; i++) begin
				b = bits[n - 1 - i];
				frame.push_back({1'b1, b ? timing_now.one_mark_us : timing_now.zero_mark_us,
					timing_now.header_space_us, 1'b0});
			end
		end
		MODE_MANCH: begin
			// start pattern, then half-bit pairs with a one sent space first
			frame.push_back({1'b1, timing_now.one_mark_us, timing_now.one_mark_us, 1'b0});
			frame.push_back({1'b1, timing_now.one_mark_us, {DUR_W{1'b0}}, 1'b0});
			for (int i = 0; i < n; i++) begin
				b = bits[n - 1 - i];
				frame.push_back({~b, timing_now.one_mark_us, timing_now.one_mark_us, 1'b0});
			end
		end
		default: ;	// unused mode: the command is swallowed
		endcase
		if (frame.size() != 0)
			frame[frame.size() - 1].last_pair = 1'b1;
		foreach (frame[i])
			pending_pairs.push_back(frame[i]);
	endfunction

	// command driver: holds each transfer until taken, idles at random
	always @(posedge clk) begin
		frame_cmd_t next_cmd;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				encode_frame(cmd_ch.payload, cmd_ch.bit_count);
				cmds_taken <= cmds_taken + 1;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = cmd_backlog.pop_front();
					cmd_ch.valid     <= 1'b1;
					cmd_ch.payload   <= next_cmd.payload;
					cmd_ch.bit_count <= next_cmd.bit_count;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// pair monitor: random back-pressure, checks every accepted pair
	always @(posedge clk) begin
		pulse_pair_t got;
		pulse_pair_t want;
		if (!arst_n) begin
			pair_ch.ready <= 1'b0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				got = {pair_ch.mark_first, pair_ch.first_duration_us,
					pair_ch.second_duration_us, pair_ch.last_pair};
				if (pending_pairs.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < REPORT_MAX)
						$display("unexpected pair: mark_first=%0d first=%0d second=%0d last=%0d",
							got.mark_first, got.first_us, got.second_us, got.last_pair);
				end else begin
					want = pending_pairs.pop_front();
					if (got.mark_first !== want.mark_first || got.first_us !== want.first_us ||
						got.second_us !== want.second_us || got.last_pair !== want.last_pair) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < REPORT_MAX)
							$display("pair mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								want.mark_first, want.first_us, want.second_us, want.last_pair,
								got.mark_first, got.first_us, got.second_us, got.last_pair);
					end
				end
			end
			pair_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_cmd(input logic [PAYLOAD_W-1:0] bits,
		input logic [BITCNT_W-1:0] count);
		cmd_backlog.push_back({bits, count});
		cmds_queued++;
	endtask

	// random frames, mostly legal sizes with some zero and oversized counts
	task automatic queue_random(input int num);
		int pick;
		logic [BITCNT_W-1:0] count;
		for (int i = 0; i < num; i++) begin
			pick = $urandom_range(9);
			if (pick == 0)
				count = '0;
			else if (pick == 1)
				count = BITCNT_W'($urandom_range(63, MAX_BITS_DEF + 1));
			else
				count = BITCNT_W'($urandom_range(MAX_BITS_DEF, 1));
			queue_cmd($urandom, count);
		end
	endtask

	// waits until every command is taken and every pair has come back
	task automatic drain();
		@(negedge clk);
		while (cmds_taken != cmds_queued || pending_pairs.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
		REG_FRAME_MODE:   timing_now.frame_mode      = value[MODE_W-1:0];
		REG_HEADER_MARK:  timing_now.header_mark_us  = value;
		REG_HEADER_SPACE: timing_now.header_space_us = value;
		REG_ONE_MARK:     timing_now.one_mark_us     = value;
		REG_ZERO_MARK:    timing_now.zero_mark_us    = value;
		REG_ONE_SPACE:    timing_now.one_space_us    = value;
		REG_ZERO_SPACE:   timing_now.zero_space_us   = value;
		default: ;
		endcase
	endtask

	// all six duration registers, either one fixed value or random
	task automatic write_durations(input bit fixed, input logic [DUR_W-1:0] value);
		for (int idx = REG_HEADER_MARK; idx <= REG_ZERO_SPACE; idx++)
			write_reg(CFG_IDX_W'(idx), fixed ? value : DUR_W'($urandom_range(65535)));
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		cmd_ch.bit_count = '0;
		pair_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		timing_now = {MODE_PDIST, RST_HEADER_MARK, RST_HEADER_SPACE, RST_ONE_MARK,
			RST_ZERO_MARK, RST_ONE_SPACE, RST_ZERO_SPACE};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			// sender light / receiver heavy, then swapped, then no idling
			if (phase < 3) begin
				send_idle_pct = 16;
				recv_idle_pct = 59;
			end else if (phase < 6) begin
				send_idle_pct = 59;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// registers only change with the block idle; an ignored frame
			// gives no pair to wait on, so let some cycles go by as well
			if (phase != 0) begin
				drain();
				repeat (SETTLE_CYCLES) @(posedge clk);
			end

			case (phase)
			0: begin
				// reset timing, pulse distance: empty frame, single bit,
				// full frame, saturated counts, alternating patterns
				queue_cmd(32'h0000_0000, 6'd0);
				queue_cmd(32'hFFFF_FFFF, 6'd1);
				queue_cmd(32'hFFFF_FFFF, 6'd32);
				queue_cmd(32'h8000_0001, 6'd32);
				queue_cmd(32'hA5A5_A5A5, 6'd33);
				queue_cmd(32'h5A5A_5A5A, 6'd63);
				queue_cmd(32'h0000_FFFF, 6'd16);
			end
			1: begin
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_PWIDTH});
				write_durations(1'b0, '0);
				queue_cmd(32'h0000_0000, 6'd0);
				queue_cmd(32'h0000_0001, 6'd1);
				queue_cmd(32'hFFFF_FFFF, 6'd32);
				queue_cmd(32'h8000_0000, 6'd32);
				queue_cmd(32'hF0F0_F0F0, 6'd63);
				// sender holds off until the whole backlog has come out
				drain();
			end
			2: begin
				// manchester, every duration at full scale, junk above the mode bits
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b1}}, MODE_MANCH});
				write_durations(1'b1, '1);
				queue_cmd(32'h0000_0000, 6'd0);
				queue_cmd(32'h0000_0001, 6'd1);
				queue_cmd(32'hFFFF_FFFF, 6'd32);
				queue_cmd(32'hAAAA_AAAA, 6'd32);
				queue_cmd(32'h5555_5555, 6'd40);
			end
			3: begin
				// mode with no meaning swallows frames; write to a hole in the map
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_UNUSED});
				write_reg(REG_UNUSED, DUR_W'($urandom_range(65535)));
				queue_cmd(32'hFFFF_FFFF, 6'd32);
				queue_cmd(32'h0000_0000, 6'd0);
				queue_cmd(32'h1234_5678, 6'd63);
			end
			4: begin
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_PDIST});
				write_durations(1'b1, '0);
			end
			5: begin
				write_reg(REG_FRAME_MODE,
					{CFG_DATA_W'($urandom_range(16383)) << MODE_W} | MODE_MANCH);
				write_durations(1'b0, '0);
			end
			6: begin
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_PWIDTH});
				write_durations(1'b0, '0);
			end
			default: begin
				write_reg(REG_FRAME_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_PDIST});
				write_durations(1'b0, '0);
			end
			endcase

			// swallowed frames only get a handful of random commands
			queue_random(phase == 3 ? 4 : RANDOM_CMDS);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_pairs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
